FILE: sv/tlr_pkg.sv
// thick line rasterizer: shared types, register indexes and reset values
// no dependencies; imported by thick_line_rasterizer
`default_nettype none

package tlr_pkg;

    // defaults for the top level parameters
    localparam int unsigned MAX_IMAGE_SIZE_DEF = 1024;
    localparam int unsigned MAX_THICKNESS_DEF  = 7;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_BRUSH_THICKNESS = 3'd2,
        REG_LINE_RED        = 3'd3,
        REG_LINE_GREEN      = 3'd4,
        REG_LINE_BLUE       = 3'd5
    } cfg_reg_t;

    // register reset values
    localparam logic [10:0] IMAGE_WIDTH_RST     = 11'd224;
    localparam logic [10:0] IMAGE_HEIGHT_RST    = 11'd224;
    localparam logic [2:0]  BRUSH_THICKNESS_RST = 3'd2;
    localparam logic [7:0]  LINE_RED_RST        = 8'd0;
    localparam logic [7:0]  LINE_GREEN_RST      = 8'd100;
    localparam logic [7:0]  LINE_BLUE_RST       = 8'd255;

    // operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [11:0] start_x;
        logic signed [11:0] start_y;
        logic signed [11:0] finish_x;
        logic signed [11:0] finish_y;
    } in_item_t;

    typedef struct packed {
        logic signed [11:0] pixel_x;
        logic signed [11:0] pixel_y;
        logic [21:0]        byte_address;
        logic               write_enable;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic               brush_last;
        logic               line_done;
    } out_item_t;

endpackage

`default_nettype wire

FILE: sv/thick_line_rasterizer.sv
// thick line rasterizer top level: line set-up, error-term stepping and brush sequencer
// depends on tlr_pkg for the beat types, register indexes and reset values
`default_nettype none

// A start beat loads both endpoints and gives no result; a line whose endpoints both
// lie beyond the same image edge is dropped at once. An advance beat takes one
// Bresenham step when accepted and hands a snapshot of the current point to the brush
// sequencer, which sends one brush pixel per cycle through the output register unless
// stalled: an advance therefore sends (2*floor(t/2)+1)^2 pixels, nine at the default
// thickness of two, and a single pixel when no line is active. The next beat is taken
// in the cycle the last pixel of a brush leaves, so brushes follow each other with no
// gap; the single pixel output port sets the rate. Pixels run column offset outer, row
// offset inner. Colour and frame size are read live while the brush is sent; the user
// must see that they are only written between lines or while idle; it is not enforced.
module thick_line_rasterizer
    import tlr_pkg::*;
#(
    parameter int unsigned MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF,
    parameter int unsigned MAX_THICKNESS  = MAX_THICKNESS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input beats
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_data,
    // result beats
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_data,
    // configuration writes
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // brush offsets run 0 .. 2*half, half at most MAX_THICKNESS/2
    localparam int unsigned HALF_MAX = MAX_THICKNESS / 2;
    localparam int unsigned OFS_W    = $clog2(2 * HALF_MAX + 2);

    // configuration registers
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [2:0]  brush_thickness_reg;
    logic [7:0]  line_red_reg;
    logic [7:0]  line_green_reg;
    logic [7:0]  line_blue_reg;

    // line state
    logic signed [11:0] cursor_x_reg, cursor_x_next;
    logic signed [11:0] cursor_y_reg, cursor_y_next;
    logic signed [11:0] target_x_reg, target_x_next;
    logic signed [11:0] target_y_reg, target_y_next;
    logic [11:0]        delta_x_reg, delta_x_next;
    logic [11:0]        delta_y_reg, delta_y_next;
    logic               step_x_negative_reg, step_x_negative_next;
    logic               step_y_negative_reg, step_y_negative_next;
    logic signed [13:0] error_term_reg, error_term_next;
    logic               line_active_reg, line_active_next;

    // brush sequencer
    logic               busy_reg, busy_next;
    logic [OFS_W-1:0]   col_ofs_reg, col_ofs_next;
    logic [OFS_W-1:0]   row_ofs_reg, row_ofs_next;
    logic [OFS_W-1:0]   half_reg, half_next;
    logic signed [11:0] centre_x_reg, centre_x_next;
    logic signed [11:0] centre_y_reg, centre_y_next;
    logic               final_pt_reg, final_pt_next;
    logic               no_line_reg, no_line_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    // effective frame size and brush
    logic [10:0] width_eff;
    logic [10:0] height_eff;
    logic [2:0]  thick_eff;

    // handshake helpers
    logic        out_load;
    logic        brush_end;
    logic        in_take;
    logic [OFS_W-1:0] span;

    // start set-up
    logic signed [12:0] sx1, sy1, sx2, sy2;
    logic signed [12:0] w_s, h_s;
    logic               reject;
    logic signed [12:0] diff_x, diff_y;

    // stepping
    logic signed [14:0] e2;
    logic signed [14:0] err_acc;
    logic               final_now;

    // pixel path
    logic signed [13:0] px_wide, py_wide;
    logic signed [13:0] w_wide, h_wide;
    logic               pix_we;
    logic [21:0]        row_base;
    logic [22:0]        lin_index;
    logic [24:0]        addr_full;
    out_item_t          pixel;

    always_comb
    begin
        width_eff  = (32'(image_width_reg) > 32'(MAX_IMAGE_SIZE))
                   ? 11'(MAX_IMAGE_SIZE) : image_width_reg;
        height_eff = (32'(image_height_reg) > 32'(MAX_IMAGE_SIZE))
                   ? 11'(MAX_IMAGE_SIZE) : image_height_reg;
        thick_eff  = (32'(brush_thickness_reg) > 32'(MAX_THICKNESS))
                   ? 3'(MAX_THICKNESS) : brush_thickness_reg;
    end

    // last pixel of the brush goes out this cycle
    assign span      = OFS_W'(half_reg << 1);
    assign out_load  = !out_valid_reg || out_ready;
    assign brush_end = busy_reg && out_load && (col_ofs_reg == span) && (row_ofs_reg == span);
    assign in_ready  = !busy_reg || brush_end;
    assign in_take   = in_valid && in_ready;

    // ---- start beat: clip test and error-term set-up ----
    always_comb
    begin
        sx1    = 13'(in_data.start_x);
        sy1    = 13'(in_data.start_y);
        sx2    = 13'(in_data.finish_x);
        sy2    = 13'(in_data.finish_y);
        w_s    = $signed({2'b00, width_eff});
        h_s    = $signed({2'b00, height_eff});
        // both endpoints beyond the same edge
        reject = (sx1 < 0 && sx2 < 0) || (sx1 >= w_s && sx2 >= w_s)
              || (sy1 < 0 && sy2 < 0) || (sy1 >= h_s && sy2 >= h_s);
        diff_x = (sx2 > sx1) ? (sx2 - sx1) : (sx1 - sx2);
        diff_y = (sy2 > sy1) ? (sy2 - sy1) : (sy1 - sy2);
    end

    // ---- advance beat: one Bresenham step ----
    always_comb
    begin
        final_now = (cursor_x_reg == target_x_reg) && (cursor_y_reg == target_y_reg);
        e2        = 15'(error_term_reg) <<< 1;
        err_acc   = 15'(error_term_reg);
        if (e2 > -$signed({3'b000, delta_y_reg}))
        begin
            err_acc = err_acc - $signed({3'b000, delta_y_reg});
        end
        if (e2 < $signed({3'b000, delta_x_reg}))
        begin
            err_acc = err_acc + $signed({3'b000, delta_x_reg});
        end
    end

    always_comb
    begin
        cursor_x_next        = cursor_x_reg;
        cursor_y_next        = cursor_y_reg;
        target_x_next        = target_x_reg;
        target_y_next        = target_y_reg;
        delta_x_next         = delta_x_reg;
        delta_y_next         = delta_y_reg;
        step_x_negative_next = step_x_negative_reg;
        step_y_negative_next = step_y_negative_reg;
        error_term_next      = error_term_reg;
        line_active_next     = line_active_reg;

        if (in_take && in_data.operation == OP_START)
        begin
            if (reject)
            begin
                line_active_next = 1'b0;
            end
            else
            begin
                cursor_x_next        = in_data.start_x;
                cursor_y_next        = in_data.start_y;
                target_x_next        = in_data.finish_x;
                target_y_next        = in_data.finish_y;
                delta_x_next         = 12'(diff_x);
                delta_y_next         = 12'(diff_y);
                step_x_negative_next = !(sx1 < sx2);
                step_y_negative_next = !(sy1 < sy2);
                error_term_next      = 14'(diff_x) - 14'(diff_y);
                line_active_next     = 1'b1;
            end
        end
        else if (in_take && line_active_reg)
        begin
            if (final_now)
            begin
                line_active_next = 1'b0;
            end
            else
            begin
                error_term_next = 14'(err_acc);
                if (e2 > -$signed({3'b000, delta_y_reg}))
                begin
                    cursor_x_next = step_x_negative_reg ? cursor_x_reg - 12'sd1
                                                        : cursor_x_reg + 12'sd1;
                end
                if (e2 < $signed({3'b000, delta_x_reg}))
                begin
                    cursor_y_next = step_y_negative_reg ? cursor_y_reg - 12'sd1
                                                        : cursor_y_reg + 12'sd1;
                end
            end
        end
    end

    // ---- brush sequencer ----
    always_comb
    begin
        busy_next     = busy_reg;
        col_ofs_next  = col_ofs_reg;
        row_ofs_next  = row_ofs_reg;
        half_next     = half_reg;
        centre_x_next = centre_x_reg;
        centre_y_next = centre_y_reg;
        final_pt_next = final_pt_reg;
        no_line_next  = no_line_reg;

        if (busy_reg && out_load)
        begin
            if (brush_end)
            begin
                busy_next = 1'b0;
            end
            else if (row_ofs_reg == span)
            begin
                row_ofs_next = '0;
                col_ofs_next = col_ofs_reg + 1'b1;
            end
            else
            begin
                row_ofs_next = row_ofs_reg + 1'b1;
            end
        end

        if (in_take && in_data.operation == OP_ADVANCE)
        begin
            busy_next     = 1'b1;
            col_ofs_next  = '0;
            row_ofs_next  = '0;
            centre_x_next = cursor_x_reg;
            centre_y_next = cursor_y_reg;
            no_line_next  = !line_active_reg;
            final_pt_next = final_now;
            // no line: a single pixel at the cursor
            half_next     = line_active_reg ? OFS_W'(thick_eff >> 1) : '0;
        end
    end

    // ---- pixel of the current offset ----
    always_comb
    begin
        px_wide = 14'(centre_x_reg) + $signed({1'b0, 13'(col_ofs_reg)})
                - $signed({1'b0, 13'(half_reg)});
        py_wide = 14'(centre_y_reg) + $signed({1'b0, 13'(row_ofs_reg)})
                - $signed({1'b0, 13'(half_reg)});
        w_wide  = $signed({3'b000, width_eff});
        h_wide  = $signed({3'b000, height_eff});
        pix_we  = !no_line_reg && (px_wide >= 0) && (px_wide < w_wide)
               && (py_wide >= 0) && (py_wide < h_wide);

        // (y*width + x)*3, kept to the port width
        row_base  = 22'(py_wide[10:0]) * 22'(width_eff);
        lin_index = 23'(row_base) + 23'(px_wide[10:0]);
        addr_full = (25'(lin_index) << 1) + 25'(lin_index);

        pixel.pixel_x      = 12'(px_wide);
        pixel.pixel_y      = 12'(py_wide);
        pixel.byte_address = pix_we ? addr_full[21:0] : '0;
        pixel.write_enable = pix_we;
        pixel.red_out      = no_line_reg ? '0 : line_red_reg;
        pixel.green_out    = no_line_reg ? '0 : line_green_reg;
        pixel.blue_out     = no_line_reg ? '0 : line_blue_reg;
        pixel.brush_last   = (col_ofs_reg == span) && (row_ofs_reg == span);
        pixel.line_done    = no_line_reg || final_pt_reg;
    end

    // ---- output register ----
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                out_data_next = pixel;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---- registers with reset ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg     <= IMAGE_WIDTH_RST;
            image_height_reg    <= IMAGE_HEIGHT_RST;
            brush_thickness_reg <= BRUSH_THICKNESS_RST;
            line_red_reg        <= LINE_RED_RST;
            line_green_reg      <= LINE_GREEN_RST;
            line_blue_reg       <= LINE_BLUE_RST;
            cursor_x_reg        <= '0;
            cursor_y_reg        <= '0;
            target_x_reg        <= '0;
            target_y_reg        <= '0;
            delta_x_reg         <= '0;
            delta_y_reg         <= '0;
            step_x_negative_reg <= 1'b0;
            step_y_negative_reg <= 1'b0;
            error_term_reg      <= '0;
            line_active_reg     <= 1'b0;
            busy_reg            <= 1'b0;
            col_ofs_reg         <= '0;
            row_ofs_reg         <= '0;
            half_reg            <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:     image_width_reg     <= cfg_data;
                    REG_IMAGE_HEIGHT:    image_height_reg    <= cfg_data;
                    REG_BRUSH_THICKNESS: brush_thickness_reg <= cfg_data[2:0];
                    REG_LINE_RED:        line_red_reg        <= cfg_data[7:0];
                    REG_LINE_GREEN:      line_green_reg      <= cfg_data[7:0];
                    REG_LINE_BLUE:       line_blue_reg       <= cfg_data[7:0];
                    default:             ;
                endcase
            end
            cursor_x_reg        <= cursor_x_next;
            cursor_y_reg        <= cursor_y_next;
            target_x_reg        <= target_x_next;
            target_y_reg        <= target_y_next;
            delta_x_reg         <= delta_x_next;
            delta_y_reg         <= delta_y_next;
            step_x_negative_reg <= step_x_negative_next;
            step_y_negative_reg <= step_y_negative_next;
            error_term_reg      <= error_term_next;
            line_active_reg     <= line_active_next;
            busy_reg            <= busy_next;
            col_ofs_reg         <= col_ofs_next;
            row_ofs_reg         <= row_ofs_next;
            half_reg            <= half_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        centre_x_reg <= centre_x_next;
        centre_y_reg <= centre_y_next;
        final_pt_reg <= final_pt_next;
        no_line_reg  <= no_line_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench for thick_line_rasterizer: a directed table of beats and register writes, then
// random lines and beats, every pixel beat checked against a hand-written result or a
// behavioural model of brush and stepping; depends on tlr_pkg and thick_line_rasterizer
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlr_pkg::*;

    localparam int SETTLE_CYCLES = 8;        // start set-up plus output register, with margin
    localparam int TOTAL_BEATS   = 260;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

    // one line of the directed table: a register write or an input beat, the latter
    // optionally with its single result written out by hand
    typedef struct packed {
        row_kind_t  kind;
        cfg_reg_t   reg_sel;
        logic [10:0] value;
        in_item_t   beat;
        logic       typed;
        out_item_t  result;
    } stim_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // travels with in_data: the hand-written result of a directed row, if it has one
    logic      beat_known       = 1'b0;
    out_item_t beat_known_pixel = '0;

    // register copies
    logic [10:0] frame_w, frame_h;
    logic [2:0]  brush_size;
    logic [7:0]  ink_red, ink_green, ink_blue;

    // line state of the model
    logic signed [11:0] pen_x, pen_y, end_x, end_y;
    logic [11:0]        run_x, run_y;
    logic               dec_x, dec_y;
    logic signed [13:0] slope_error;
    logic               line_live;

    out_item_t brush_pixels[$];     // pixels of the beat just traced
    out_item_t pending_pixels[$];   // pixels still to come out, oldest first
    stim_row_t directed_rows[$];

    int   fault_count = 0;
    int   cycle_count = 0;
    int   beats_sent  = 0;
    int   ready_hold  = 0;
    logic calm        = 1'b0;       // no idling on either side while set

    thick_line_rasterizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout with %0d pixels outstanding", pending_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- helpers

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap(int idle_pct);
        if (calm || $urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int fit12(int v);
        return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
    endfunction

    function automatic in_item_t make_item(logic op, int sx, int sy, int fx, int fy);
        in_item_t b;
        b.operation = op;
        b.start_x   = sx[11:0];
        b.start_y   = sy[11:0];
        b.finish_x  = fx[11:0];
        b.finish_y  = fy[11:0];
        return b;
    endfunction

    function automatic in_item_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    // what an advance gives when no line is being drawn
    function automatic out_item_t no_line(logic signed [11:0] x, logic signed [11:0] y);
        out_item_t p;
        p = '0;
        p.pixel_x    = x;
        p.pixel_y    = y;
        p.brush_last = 1'b1;
        p.line_done  = 1'b1;
        return p;
    endfunction

    function automatic stim_row_t write_row(cfg_reg_t r, logic [10:0] v);
        stim_row_t row;
        row = '0;
        row.kind    = ROW_WRITE;
        row.reg_sel = r;
        row.value   = v;
        return row;
    endfunction

    function automatic stim_row_t beat_row(logic op, int sx, int sy, int fx, int fy);
        stim_row_t row;
        row = '0;
        row.kind = ROW_BEAT;
        row.beat = make_item(op, sx, sy, fx, fy);
        return row;
    endfunction

    function automatic stim_row_t known_row(out_item_t pix);
        stim_row_t row;
        row = beat_row(OP_ADVANCE, 0, 0, 0, 0);
        row.typed  = 1'b1;
        row.result = pix;
        return row;
    endfunction

    function automatic string describe(out_item_t p);
        return $sformatf("x=%0d y=%0d addr=%0d we=%0b rgb=%0d/%0d/%0d last=%0b done=%0b",
                         p.pixel_x, p.pixel_y, p.byte_address, p.write_enable,
                         p.red_out, p.green_out, p.blue_out, p.brush_last, p.line_done);
    endfunction

    // ------------------------------------------------------------- prediction

    // works out the pixels of one accepted beat into brush_pixels and moves the line on
    task automatic rasterize_beat(input in_item_t b);
        int        w, h, x1, y1, x2, y2, dx, dy, e, e2;
        int        half, total, n, t, u, cx, cy, px, py, addr;
        logic      on_frame, final_pt;
        out_item_t p;

        w = (frame_w > MAX_IMAGE_SIZE_DEF) ? MAX_IMAGE_SIZE_DEF : frame_w;
        h = (frame_h > MAX_IMAGE_SIZE_DEF) ? MAX_IMAGE_SIZE_DEF : frame_h;
        brush_pixels.delete();

        if (b.operation == OP_START)
        begin
            x1 = int'(b.start_x);
            y1 = int'(b.start_y);
            x2 = int'(b.finish_x);
            y2 = int'(b.finish_y);
            // both ends beyond one edge: nothing to draw
            if ((x1 < 0 && x2 < 0) || (x1 >= w && x2 >= w) ||
                (y1 < 0 && y2 < 0) || (y1 >= h && y2 >= h))
            begin
                line_live = 1'b0;
            end
            else
            begin
                dx          = (x2 > x1) ? x2 - x1 : x1 - x2;
                dy          = (y2 > y1) ? y2 - y1 : y1 - y2;
                e           = dx - dy;
                pen_x       = b.start_x;
                pen_y       = b.start_y;
                end_x       = b.finish_x;
                end_y       = b.finish_y;
                run_x       = dx[11:0];
                run_y       = dy[11:0];
                dec_x       = !(x1 < x2);
                dec_y       = !(y1 < y2);
                slope_error = e[13:0];
                line_live   = 1'b1;
            end
        end
        else if (!line_live)
        begin
            brush_pixels.push_back(no_line(pen_x, pen_y));
        end
        else
        begin
            half     = ((brush_size > MAX_THICKNESS_DEF) ? MAX_THICKNESS_DEF : brush_size) / 2;
            total    = (2 * half + 1) * (2 * half + 1);
            final_pt = (pen_x == end_x) && (pen_y == end_y);
            cx       = int'(pen_x);
            cy       = int'(pen_y);
            n        = 0;
            // column offset outer, row offset inner
            for (t = -half; t <= half; t++)
            begin
                for (u = -half; u <= half; u++)
                begin
                    px       = cx + t;
                    py       = cy + u;
                    on_frame = (px >= 0) && (px < w) && (py >= 0) && (py < h);
                    addr     = (py * w + px) * 3;
                    p.pixel_x      = px[11:0];
                    p.pixel_y      = py[11:0];
                    p.byte_address = on_frame ? addr[21:0] : '0;
                    p.write_enable = on_frame;
                    p.red_out      = ink_red;
                    p.green_out    = ink_green;
                    p.blue_out     = ink_blue;
                    p.brush_last   = (n + 1 == total);
                    p.line_done    = final_pt;
                    brush_pixels.push_back(p);
                    n++;
                end
            end
            if (final_pt)
            begin
                line_live = 1'b0;
            end
            else
            begin
                // one error-term step, possibly diagonal
                dx = int'(run_x);
                dy = int'(run_y);
                e  = int'(slope_error);
                e2 = 2 * e;
                if (e2 > -dy)
                begin
                    e  = e - dy;
                    cx = cx + (dec_x ? -1 : 1);
                end
                if (e2 < dx)
                begin
                    e  = e + dx;
                    cy = cy + (dec_y ? -1 : 1);
                end
                pen_x       = cx[11:0];
                pen_y       = cy[11:0];
                slope_error = e[13:0];
            end
        end
    endtask

    task automatic check_pixel(input out_item_t got);
        out_item_t want;
        string     bad;
        if (pending_pixels.size() == 0)
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("pixel beat with nothing expected: %s", describe(got));
        end
        else
        begin
            want = pending_pixels.pop_front();
            bad  = "";
            if (got.pixel_x      !== want.pixel_x)      bad = {bad, " pixel_x"};
            if (got.pixel_y      !== want.pixel_y)      bad = {bad, " pixel_y"};
            if (got.byte_address !== want.byte_address) bad = {bad, " byte_address"};
            if (got.write_enable !== want.write_enable) bad = {bad, " write_enable"};
            if (got.red_out      !== want.red_out)      bad = {bad, " red_out"};
            if (got.green_out    !== want.green_out)    bad = {bad, " green_out"};
            if (got.blue_out     !== want.blue_out)     bad = {bad, " blue_out"};
            if (got.brush_last   !== want.brush_last)   bad = {bad, " brush_last"};
            if (got.line_done    !== want.line_done)    bad = {bad, " line_done"};
            if (bad != "")
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("pixel mismatch in%s\n  expected %s\n  actual   %s",
                             bad, describe(want), describe(got));
            end
        end
    endtask

    // follows both ports and the register writes at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w     = IMAGE_WIDTH_RST;
            frame_h     = IMAGE_HEIGHT_RST;
            brush_size  = BRUSH_THICKNESS_RST;
            ink_red     = LINE_RED_RST;
            ink_green   = LINE_GREEN_RST;
            ink_blue    = LINE_BLUE_RST;
            pen_x       = '0;
            pen_y       = '0;
            end_x       = '0;
            end_y       = '0;
            run_x       = '0;
            run_y       = '0;
            dec_x       = 1'b0;
            dec_y       = 1'b0;
            slope_error = '0;
            line_live   = 1'b0;
            pending_pixels.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:     frame_w    = cfg_data[10:0];
                    REG_IMAGE_HEIGHT:    frame_h    = cfg_data[10:0];
                    REG_BRUSH_THICKNESS: brush_size = cfg_data[2:0];
                    REG_LINE_RED:        ink_red    = cfg_data[7:0];
                    REG_LINE_GREEN:      ink_green  = cfg_data[7:0];
                    REG_LINE_BLUE:       ink_blue   = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                rasterize_beat(in_data);
                // a hand-written result takes the place of the model's
                if (beat_known)
                    pending_pixels.push_back(beat_known_pixel);
                else
                    foreach (brush_pixels[i])
                        pending_pixels.push_back(brush_pixels[i]);
            end
            if (out_valid && out_ready)
                check_pixel(out_data);
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold = ready_hold - 1;
        else
            ready_hold = pick_gap(25);
        out_ready <= (ready_hold == 0);
    end

    // ---------------------------------------------------------------- driving

    // valid stays high across back-to-back beats, lowered only for a gap
    task automatic send_beat(input in_item_t b, input logic known, input out_item_t known_pixel);
        int gap;
        gap = pick_gap(40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        in_data          <= b;
        beat_known       <= known;
        beat_known_pixel <= known_pixel;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    // wait for the last pixel, then for the block to go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [10:0] v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // small frames most of the time so that clipping is common
    function automatic logic [10:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 11'($urandom_range(1, 40));
        if (r < 15) return 11'($urandom_range(200, 260));
        if (r < 17) return 11'($urandom_range(1024, 2047));
        if (r < 18) return '0;
        return 11'($urandom_range(0, 2047));
    endfunction

    // narrow registers now and then get junk above their width
    function automatic logic [10:0] with_stray_bits(logic [7:0] v);
        logic [2:0] top;
        top = 3'($urandom_range(0, 7));
        return ($urandom_range(0, 3) == 0) ? {top, v} : {3'b000, v};
    endfunction

    function automatic logic [7:0] pick_colour();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // a short line near the frame, walked to its end, cut short or overrun by one
    task automatic run_line();
        int       w, h, x1, y1, x2, y2, steps, ax, ay;
        in_item_t b;
        w  = (frame_w > MAX_IMAGE_SIZE_DEF) ? MAX_IMAGE_SIZE_DEF : frame_w;
        h  = (frame_h > MAX_IMAGE_SIZE_DEF) ? MAX_IMAGE_SIZE_DEF : frame_h;
        x1 = int'($urandom_range(0, w + 7)) - 4;
        y1 = int'($urandom_range(0, h + 7)) - 4;
        x2 = fit12(x1 + int'($urandom_range(0, 24)) - 12);
        y2 = fit12(y1 + int'($urandom_range(0, 24)) - 12);
        send_beat(make_item(OP_START, x1, y1, x2, y2), 1'b0, '0);
        ax    = (x2 > x1) ? x2 - x1 : x1 - x2;
        ay    = (y2 > y1) ? y2 - y1 : y1 - y2;
        steps = ((ax > ay) ? ax : ay) + 1;
        case ($urandom_range(0, 9))
            0:       steps = $urandom_range(1, steps);
            1:       steps = steps + 1;
            default: ;
        endcase
        repeat (steps)
        begin
            b = random_item();
            b.operation = OP_ADVANCE;
            send_beat(b, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------ test

    initial
    begin
        // directed rows, among them the corner pixel of a full 1024 frame, thickness 0, colour 255/0/85
        directed_rows.push_back(known_row(no_line(12'sd0, 12'sd0)));  // advance straight after reset
        directed_rows.push_back(beat_row(OP_START, 0, 0, 3, 2));
        repeat (4) directed_rows.push_back(beat_row(OP_ADVANCE, 0, 0, 0, 0));
        directed_rows.push_back(known_row(no_line(12'sd3, 12'sd2)));  // line already finished
        directed_rows.push_back(beat_row(OP_START, -5, 10, -1, 20));  // both left of frame
        directed_rows.push_back(beat_row(OP_START, 5, 224, 6, 2047)); // both below frame
        directed_rows.push_back(known_row(no_line(12'sd3, 12'sd2)));
        directed_rows.push_back(beat_row(OP_START, 220, 220, 230, 221)); // runs off right edge
        directed_rows.push_back(beat_row(OP_ADVANCE, 0, 0, 0, 0));
        directed_rows.push_back(write_row(REG_BRUSH_THICKNESS, 11'd7)); // change mid-line
        directed_rows.push_back(beat_row(OP_ADVANCE, 0, 0, 0, 0));
        directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 11'd2047));  // saturates
        directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 11'd1024));
        directed_rows.push_back(write_row(REG_BRUSH_THICKNESS, 11'd0));
        directed_rows.push_back(write_row(REG_LINE_RED, 11'd255));
        directed_rows.push_back(write_row(REG_LINE_GREEN, 11'd0));
        directed_rows.push_back(write_row(REG_LINE_BLUE, 11'd85));
        directed_rows.push_back(beat_row(OP_START, 1023, 1023, 1023, 1023));
        directed_rows.push_back(known_row({12'd1023, 12'd1023, 22'd3145725, 1'b1,
                                           8'd255, 8'd0, 8'd85, 1'b1, 1'b1}));
        directed_rows.push_back(beat_row(OP_START, -2048, -2048, 2047, 2047));
        directed_rows.push_back(beat_row(OP_ADVANCE, 0, 0, 0, 0));
        directed_rows.push_back(beat_row(OP_START, 2047, -2048, -2048, 2047));
        directed_rows.push_back(write_row(REG_BRUSH_THICKNESS, 11'd7)); // brush wraps at 12 bits
        directed_rows.push_back(beat_row(OP_ADVANCE, 0, 0, 0, 0));
        directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 11'd0));     // everything clipped
        directed_rows.push_back(beat_row(OP_START, -1, 0, 5, 3));
        directed_rows.push_back(beat_row(OP_ADVANCE, 0, 0, 0, 0));
        directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 11'd1));
        directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 11'd1));
        directed_rows.push_back(write_row(REG_BRUSH_THICKNESS, 11'd2));
        directed_rows.push_back(beat_row(OP_START, 0, 0, 0, 1));
        directed_rows.push_back(beat_row(OP_ADVANCE, 0, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
            end
            else
            begin
                send_beat(directed_rows[i].beat, directed_rows[i].typed,
                          directed_rows[i].result);
            end
        end

        // random phases: fresh registers, then a handful of lines and some noise
        while (beats_sent < TOTAL_BEATS)
        begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            write_reg(REG_IMAGE_WIDTH, pick_size());
            write_reg(REG_IMAGE_HEIGHT, pick_size());
            write_reg(REG_BRUSH_THICKNESS, with_stray_bits(($urandom_range(0, 7) < 6) ?
                      8'($urandom_range(0, 3)) : 8'($urandom_range(4, 7))));
            write_reg(REG_LINE_RED, with_stray_bits(pick_colour()));
            write_reg(REG_LINE_GREEN, with_stray_bits(pick_colour()));
            write_reg(REG_LINE_BLUE, with_stray_bits(pick_colour()));
            repeat ($urandom_range(2, 5))
            begin
                if ($urandom_range(0, 4) != 0)
                    run_line();
                else
                    repeat ($urandom_range(1, 3)) send_beat(random_item(), 1'b0, '0);
            end
        end

        settle();
        if (fault_count == 0 && pending_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
